// File: rtl/apn_pkg.sv
// shared types, codes and sizes of the absolute path normalizer
// no dependencies; apn_front, apn_back and the core refer to it by scoped names
`default_nettype none

package apn_pkg;

    localparam int PATH_MAX  = 4096;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 12;
    localparam int LEN_W     = 12;
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        DOTS_NONE  = 2'd0,
        DOTS_ONE   = 2'd1,
        DOTS_TWO   = 2'd2,
        DOTS_OTHER = 2'd3
    } t_dots;

    typedef struct packed {
        t_kind              kind;
        logic               last;
        logic               is_slash;
        logic               is_dot;
        logic               malformed;
        logic               idx_ok;
        logic [BYTE_W-1:0]  path_byte;
        logic [IDX_W-1:0]   read_index;
    } t_item;

    typedef struct packed {
        logic               is_readback;
        t_status            status;
        logic [LEN_W-1:0]   length;
        logic [BYTE_W-1:0]  read_byte;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/apn_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module apn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/apn_fifo.sv
// small register queue, used between front and back and for results
// no dependencies
`default_nettype none

module apn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data,
    output logic      [CNT_W-1:0] o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             push_go;
    logic             pop_go;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign push_go = i_push && !o_full;
    assign pop_go  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push_go) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop_go) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({push_go, pop_go})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_go) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/apn_front.sv
// front end: takes input beats, classifies the byte and tracks the first byte of a path
// depends on apn_pkg
`default_nettype none

module apn_front #(
    parameter int PATH_MAX = apn_pkg::PATH_MAX
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic                       i_kind,
    input  wire logic [apn_pkg::BYTE_W-1:0] i_path_byte,
    input  wire logic                       i_last,
    input  wire logic [apn_pkg::IDX_W-1:0]  i_read_index,
    input  wire logic                       i_mid_full,
    output logic                            o_push,
    output apn_pkg::t_item                  o_item
);

    logic r_first;
    logic n_first;
    logic accept;

    assign accept = i_push && !i_mid_full;
    assign o_push = i_push;

    always_comb begin
        o_item.kind       = apn_pkg::t_kind'(i_kind);
        o_item.last       = i_last;
        o_item.is_slash   = (i_path_byte == apn_pkg::CH_SLASH);
        o_item.is_dot     = (i_path_byte == apn_pkg::CH_DOT);
        o_item.malformed  = r_first && (i_path_byte != apn_pkg::CH_SLASH);
        o_item.idx_ok     = (32'(i_read_index) < 32'(PATH_MAX));
        o_item.path_byte  = i_path_byte;
        o_item.read_index = i_read_index;
    end

    always_comb begin
        n_first = r_first;
        if (accept && (apn_pkg::t_kind'(i_kind) == apn_pkg::KIND_BYTE)) begin
            n_first = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else begin
            r_first <= n_first;
        end
    end

endmodule

`default_nettype wire

// File: rtl/apn_back.sv
// back end: path engine with component stack, path buffer and result stage
// depends on apn_pkg and apn_ram
`default_nettype none

module apn_back #(
    parameter int PATH_MAX = apn_pkg::PATH_MAX
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_mid_empty,
    input  apn_pkg::t_item                     i_item,
    output logic                               o_mid_pop,
    input  wire logic [apn_pkg::OUT_CNT_W-1:0] i_out_count,
    output logic                               o_res_push,
    output apn_pkg::t_result                   o_res
);

    localparam int AW  = $clog2(PATH_MAX);
    localparam int PW  = $clog2(PATH_MAX + 1);
    localparam int SD  = PATH_MAX / 2;
    localparam int SAW = $clog2(SD);
    localparam int OCW = apn_pkg::OUT_CNT_W;

    // path engine state
    logic [PW-1:0]           r_wp;
    logic [PW-1:0]           r_clen;
    apn_pkg::t_dots          r_dots;
    apn_pkg::t_status        r_err;
    logic                    r_tail;
    logic [SAW-1:0]          r_sp;
    logic [AW-1:0]           r_top;
    logic                    r_sp_moved;
    logic [PW-1:0]           n_wp;
    logic [PW-1:0]           n_clen;
    apn_pkg::t_dots          n_dots;
    apn_pkg::t_status        n_err;
    logic                    n_tail;
    logic [SAW-1:0]          n_sp;
    logic [AW-1:0]           n_top;

    // result stage
    logic                    r_s2_v;
    logic                    r_s2_rb;
    apn_pkg::t_status        r_s2_status;
    logic [apn_pkg::LEN_W-1:0] r_s2_len;
    logic                    r_s2_rb_ok;

    // datapath
    apn_pkg::t_status        err_in;
    apn_pkg::t_status        err_e;
    logic                    other;
    logic [PW-1:0]           clen_inc;
    logic [PW-1:0]           clen_c;
    apn_pkg::t_dots          dots_inc;
    apn_pkg::t_dots          dots_c;
    logic                    end_c;
    logic [PW:0]             sum;
    logic [PW:0]             pos;
    logic [PW-1:0]           wp_e;
    logic [PW-1:0]           wp_f;
    logic                    tail_e;
    logic                    st_push;
    logic                    st_pop;
    logic                    wr_slash;
    logic                    wr_other;
    logic                    pop_need;
    logic                    stall;
    logic                    need_slot;
    logic                    slot_ok;
    logic                    is_byte;
    logic                    go;
    logic [apn_pkg::LEN_W-1:0] len_out;
    apn_pkg::t_status        st_out;

    // memories
    logic                    pm_we;
    logic [AW-1:0]           pm_waddr;
    logic [apn_pkg::BYTE_W-1:0] pm_wdata;
    logic [apn_pkg::BYTE_W-1:0] pm_rdata;
    logic [AW-1:0]           st_rdata;

    assign is_byte   = (i_item.kind == apn_pkg::KIND_BYTE);
    assign need_slot = !is_byte || i_item.last;
    assign slot_ok   = (({1'b0, i_out_count} + (OCW + 1)'(r_s2_v)) <
                        (OCW + 1)'(apn_pkg::OUT_DEPTH));

    always_comb begin
        err_in   = i_item.malformed ? apn_pkg::ST_MALFORMED : r_err;
        other    = (err_in == apn_pkg::ST_OK) && !i_item.is_slash;
        clen_inc = (r_clen == PW'(PATH_MAX)) ? r_clen : r_clen + PW'(1);
        priority if (i_item.is_dot && (r_dots == apn_pkg::DOTS_NONE)) begin
            dots_inc = apn_pkg::DOTS_ONE;
        end else if (i_item.is_dot && (r_dots == apn_pkg::DOTS_ONE)) begin
            dots_inc = apn_pkg::DOTS_TWO;
        end else begin
            dots_inc = apn_pkg::DOTS_OTHER;
        end
        clen_c = other ? clen_inc : r_clen;
        dots_c = other ? dots_inc : r_dots;
        pos    = {1'b0, r_wp} + {1'b0, r_clen};
        sum    = {1'b0, r_wp} + {1'b0, clen_c};
        end_c  = (err_in == apn_pkg::ST_OK) && (i_item.is_slash || i_item.last) &&
                 (clen_c != '0);

        // end of component
        wp_e    = r_wp;
        tail_e  = r_tail;
        err_e   = err_in;
        st_push = 1'b0;
        st_pop  = 1'b0;
        if (end_c) begin
            priority if (dots_c == apn_pkg::DOTS_ONE) begin
                tail_e = r_tail;
            end else if (dots_c == apn_pkg::DOTS_TWO) begin
                tail_e = 1'b1;
                if (r_sp != '0) begin
                    wp_e   = PW'(r_top);
                    st_pop = 1'b1;
                end
            end else if (sum >= (PW + 1)'(PATH_MAX)) begin
                err_e = apn_pkg::ST_OVERFLOW;
            end else begin
                wp_e    = PW'(sum);
                tail_e  = 1'b0;
                st_push = 1'b1;
            end
        end

        // slash after the component
        wp_f     = wp_e;
        n_tail   = tail_e;
        n_err    = err_e;
        wr_slash = 1'b0;
        if (i_item.is_slash && (err_e == apn_pkg::ST_OK) && !tail_e) begin
            if (wp_e >= PW'(PATH_MAX - 1)) begin
                n_err = apn_pkg::ST_OVERFLOW;
            end else begin
                wr_slash = 1'b1;
                wp_f     = wp_e + PW'(1);
                n_tail   = 1'b1;
            end
        end
        wr_other = other && (pos < (PW + 1)'(PATH_MAX));

        // trailing slash strip on the final byte
        if ((n_err == apn_pkg::ST_OK) && n_tail && (wp_f > PW'(1))) begin
            len_out = apn_pkg::LEN_W'(wp_f - PW'(1));
        end else if (n_err == apn_pkg::ST_OK) begin
            len_out = apn_pkg::LEN_W'(wp_f);
        end else begin
            len_out = '0;
        end
        st_out = n_err;

        n_wp   = wp_f;
        n_clen = end_c ? '0 : clen_c;
        n_dots = end_c ? apn_pkg::DOTS_NONE : dots_c;
        n_sp   = r_sp;
        n_top  = r_top;
        if (st_push) begin
            n_sp  = r_sp + SAW'(1);
            n_top = AW'(r_wp);
        end else if (st_pop) begin
            n_sp  = r_sp - SAW'(1);
            n_top = st_rdata;
        end
        if (i_item.last) begin
            n_wp   = '0;
            n_clen = '0;
            n_dots = apn_pkg::DOTS_NONE;
            n_err  = apn_pkg::ST_OK;
            n_tail = 1'b0;
            n_sp   = '0;
        end
    end

    // the entry below the top is read ahead from the registered stack ram; a pop stalls while r_sp_moved is set
    assign pop_need  = is_byte && st_pop && (r_sp > SAW'(1));
    assign stall     = pop_need && r_sp_moved;
    assign go        = !i_mid_empty && (!need_slot || slot_ok) && !stall;
    assign o_mid_pop = go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_clen     <= '0;
            r_dots     <= apn_pkg::DOTS_NONE;
            r_err      <= apn_pkg::ST_OK;
            r_tail     <= 1'b0;
            r_sp       <= '0;
            r_sp_moved <= 1'b0;
            r_s2_v     <= 1'b0;
        end else begin
            r_s2_v     <= go && need_slot;
            r_sp_moved <= 1'b0;
            if (go && is_byte) begin
                r_wp       <= n_wp;
                r_clen     <= n_clen;
                r_dots     <= n_dots;
                r_err      <= n_err;
                r_tail     <= n_tail;
                r_sp       <= n_sp;
                r_sp_moved <= (n_sp != r_sp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && is_byte) begin
            r_top <= n_top;
        end
        if (go) begin
            r_s2_rb     <= !is_byte;
            r_s2_status <= is_byte ? st_out : apn_pkg::ST_OK;
            r_s2_len    <= is_byte ? len_out : '0;
            r_s2_rb_ok  <= !is_byte && i_item.idx_ok;
        end
    end

    assign pm_we    = go && is_byte && (wr_slash || wr_other);
    assign pm_waddr = wr_slash ? AW'(wp_e) : AW'(pos);
    assign pm_wdata = wr_slash ? apn_pkg::CH_SLASH : i_item.path_byte;

    apn_ram #(
        .WIDTH(apn_pkg::BYTE_W),
        .DEPTH(PATH_MAX)
    ) u_path_ram (
        .i_clk  (i_clk),
        .i_we   (pm_we),
        .i_waddr(pm_waddr),
        .i_wdata(pm_wdata),
        .i_raddr(AW'(i_item.read_index)),
        .o_rdata(pm_rdata)
    );

    apn_ram #(
        .WIDTH(AW),
        .DEPTH(SD)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (go && is_byte && st_push),
        .i_waddr(r_sp),
        .i_wdata(AW'(r_wp)),
        .i_raddr(r_sp - SAW'(2)),
        .o_rdata(st_rdata)
    );

    assign o_res_push        = r_s2_v;
    assign o_res.is_readback = r_s2_rb;
    assign o_res.status      = r_s2_status;
    assign o_res.length      = r_s2_len;
    assign o_res.read_byte   = r_s2_rb_ok ? pm_rdata : '0;

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp < PW'(PATH_MAX))
        else $error("committed length out of range");

    a_root_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp == '0) |-> (r_wp <= PW'(1)))
        else $error("empty component stack with a deeper path");

    a_out_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (i_out_count < OCW'(apn_pkg::OUT_DEPTH)))
        else $error("result pushed into a full queue");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && is_byte && i_item.last) |=> (r_s2_v && !r_s2_rb))
        else $error("final path byte gave no status beat");

endmodule

`default_nettype wire

// File: rtl/absolute_path_normalizer_core.sv
// top level of the absolute path normalizer: front, queue, back engine, result queue
// depends on apn_pkg, apn_front, apn_fifo, apn_back
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | push / full        | i_kind, i_path_byte, i_last, i_read_index
//  result   | empty / pop        | o_is_readback, o_status, o_length, o_read_byte
//
// one item per cycle while no queue is full and the back engine does not stall;
// a result passes the mid queue, the result stage and the result queue
// a '..' right after a stack move stalls the back engine for the stack ram read
// synchronous active low reset clears control state only; buffers need no clearing
// a full result queue stalls the back engine, a full input queue raises full
`default_nettype none

module absolute_path_normalizer_core #(
    parameter int PATH_MAX = apn_pkg::PATH_MAX
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       i_kind,
    input  wire logic [apn_pkg::BYTE_W-1:0] i_path_byte,
    input  wire logic                       i_last,
    input  wire logic [apn_pkg::IDX_W-1:0]  i_read_index,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_is_readback,
    output logic [1:0]                      o_status,
    output logic [apn_pkg::LEN_W-1:0]       o_length,
    output logic [apn_pkg::BYTE_W-1:0]      o_read_byte
);

    logic                            front_push;
    apn_pkg::t_item                  front_item;
    logic                            mid_empty;
    logic                            mid_pop;
    apn_pkg::t_item                  mid_item;
    logic                            res_push;
    apn_pkg::t_result                res;
    apn_pkg::t_result                out_res;
    logic [apn_pkg::OUT_CNT_W-1:0]   out_count;

    apn_front #(
        .PATH_MAX(PATH_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_kind      (i_kind),
        .i_path_byte (i_path_byte),
        .i_last      (i_last),
        .i_read_index(i_read_index),
        .i_mid_full  (full),
        .o_push      (front_push),
        .o_item      (front_item)
    );

    apn_fifo #(
        .WIDTH($bits(apn_pkg::t_item)),
        .DEPTH(apn_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_data (front_item),
        .o_full (full),
        .i_pop  (mid_pop),
        .o_empty(mid_empty),
        .o_data (mid_item),
        .o_count()
    );

    apn_back #(
        .PATH_MAX(PATH_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mid_empty(mid_empty),
        .i_item     (mid_item),
        .o_mid_pop  (mid_pop),
        .i_out_count(out_count),
        .o_res_push (res_push),
        .o_res      (res)
    );

    apn_fifo #(
        .WIDTH($bits(apn_pkg::t_result)),
        .DEPTH(apn_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res),
        .o_full (),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (out_res),
        .o_count(out_count)
    );

    assign o_is_readback = out_res.is_readback;
    assign o_status      = out_res.status;
    assign o_length      = out_res.length;
    assign o_read_byte   = out_res.read_byte;

endmodule

`default_nettype wire
